### src/bdc_pkg.sv
// Shared types, register indexes and reset values for the button debounce
// and click detector. No dependencies.
`default_nettype none

package bdc_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W  = 15;
  localparam int unsigned TOL_W     = 14;
  localparam int unsigned INERTIA_W = 8;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;

  // Depth of the front-to-back and result queues
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_VALUE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INERTIA_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 2'd3;

  // Reset values: 1.0 and 0.05 in Q2.13, 3 samples, 0.5 s
  localparam logic signed [SAMPLE_W-1:0] ACTIVE_VALUE_RST  = 15'sd8192;
  localparam logic [TOL_W-1:0]           TOLERANCE_RST     = 14'd410;
  localparam logic [INERTIA_W-1:0]       INERTIA_LIMIT_RST = 8'd3;
  localparam logic [TIME_W-1:0]          HOLD_TIME_RST     = 32'd500000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] active_value;
    logic [TOL_W-1:0]           tolerance;
    logic [INERTIA_W-1:0]       inertia_limit;
    logic [TIME_W-1:0]          hold_time_us;
  } cfg_t;

  // Classified sample handed from front to back
  typedef struct packed {
    logic              active;
    logic [TIME_W-1:0] now_us;
  } item_t;

  // One result item
  typedef struct packed {
    logic debounced_state;
    logic lazy_state;
    logic press_event;
    logic single_event;
    logic double_event;
  } result_t;

endpackage

`default_nettype wire

### src/bdc_queue.sv
// Small first-in first-out queue of register entries with push/full and
// pop/empty sides. Depends on nothing; width and depth come from the parent.
`default_nettype none

module bdc_queue #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 2   // 2 or more
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entry on transfer in
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

### src/bdc_front.sv
// Front end: takes input samples and classifies each as active or not by
// its distance from the active value. Depends on bdc_pkg.
`default_nettype none

module bdc_front import bdc_pkg::*; (
  input  wire logic                       in_push,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic [TIME_W-1:0]          in_now_us,
  output logic                            in_full,
  input  wire cfg_t                       cfg,
  output logic                            q_push,
  output item_t                           q_item,
  input  wire logic                       q_full
);

  logic signed [SAMPLE_W:0] delta;
  logic [SAMPLE_W:0]        mag;

  // Form the distance exactly at one extra bit, then take its magnitude
  always_comb begin
    delta = {in_sample[SAMPLE_W-1], in_sample}
          - {cfg.active_value[SAMPLE_W-1], cfg.active_value};
    mag   = delta[SAMPLE_W] ? (~delta + 1'b1) : delta;
  end

  // Pass the classified sample straight into the queue
  assign q_item.active = (mag <= {{(SAMPLE_W + 1 - TOL_W){1'b0}}, cfg.tolerance});
  assign q_item.now_us = in_now_us;
  assign q_push        = in_push && !q_full;
  assign in_full       = q_full;

endmodule

`default_nettype wire

### src/bdc_back.sv
// Back end: debounce, lazy state and click detection over classified samples,
// one per cycle while the result queue has room. Depends on bdc_pkg.
`default_nettype none

module bdc_back import bdc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire item_t q_item,
  input  wire logic  q_empty,
  output logic       q_pop,
  output logic       r_push,
  output result_t    r_data,
  input  wire logic  r_full
);

  logic [INERTIA_W-1:0] inertia_r, inertia_nxt;
  // current state before the update doubles as the previous state
  logic                 cur_r, cur_nxt;
  logic                 slow_r, slow_nxt;
  logic                 armed_r, armed_nxt;
  logic                 pend_r, pend_nxt;
  logic [TIME_W-1:0]    edge_time_r, edge_time_nxt;
  logic [TIME_W-1:0]    elapsed;
  logic                 step;

  assign step    = !q_empty && !r_full;
  assign q_pop   = step;
  assign r_push  = step;
  assign elapsed = q_item.now_us - edge_time_r;

  // Update debounce and click state for one sample
  always_comb begin
    inertia_nxt   = inertia_r;
    cur_nxt       = cur_r;
    slow_nxt      = slow_r;
    armed_nxt     = armed_r;
    pend_nxt      = pend_r;
    edge_time_nxt = edge_time_r;
    r_data        = '0;

    // Count active samples; drop at once on an inactive one
    if (!q_item.active) begin
      inertia_nxt = '0;
      cur_nxt     = 1'b0;
    end else if (inertia_r < cfg.inertia_limit) begin
      inertia_nxt = inertia_r + 1'b1;
    end else begin
      cur_nxt = 1'b1;
    end

    if (cur_nxt != cur_r) begin
      // Edge: stamp it, arm on rise, count the click on release
      edge_time_nxt = q_item.now_us;
      if (cur_nxt) begin
        armed_nxt = 1'b1;
      end else begin
        slow_nxt = 1'b0;
        if (armed_r) begin
          if (pend_r) begin
            r_data.double_event = 1'b1;
            pend_nxt            = 1'b0;
          end else begin
            pend_nxt = 1'b1;
          end
          armed_nxt = 1'b0;
        end
      end
    end else if (elapsed > cfg.hold_time_us) begin
      // Quiet long enough: settle lazy state and any single click
      r_data.press_event  = cur_nxt && !slow_r;
      slow_nxt            = cur_nxt;
      r_data.single_event = !cur_nxt && pend_r;
      pend_nxt            = 1'b0;
      armed_nxt           = 1'b0;
    end

    r_data.debounced_state = cur_nxt;
    r_data.lazy_state      = slow_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inertia_r   <= '0;
      cur_r       <= 1'b0;
      slow_r      <= 1'b0;
      armed_r     <= 1'b0;
      pend_r      <= 1'b0;
      edge_time_r <= '0;
    end else if (step) begin
      inertia_r   <= inertia_nxt;
      cur_r       <= cur_nxt;
      slow_r      <= slow_nxt;
      armed_r     <= armed_nxt;
      pend_r      <= pend_nxt;
      edge_time_r <= edge_time_nxt;
    end
  end

endmodule

`default_nettype wire

### src/button_debounce_click_detector.sv
// Top level of the button debouncer with click detection: configuration
// registers, front end, item queue, back end and result queue.
// Depends on bdc_pkg, bdc_front, bdc_queue and bdc_back.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_push / in_full   in_sample, in_now_us
//   out_     output     out_pop / out_empty debounced, lazy, press, single, double
//   cfg_     input      cfg_we              cfg_index, cfg_wdata
//
// One item per cycle sustained while the result side keeps popping; an item's
// result reaches the result ports through the item queue, then the result
// queue, which the back end writes as it pops the item queue.
// The back end's state update is the one per-item loop. A stalled result side
// fills the result queue, then the item queue, then raises in_full. Reset
// empties both queues, clears the back-end state and loads the register defaults.
`default_nettype none

module button_debounce_click_detector import bdc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic [TIME_W-1:0]          in_now_us,
  output logic                            out_empty,
  input  wire logic                       out_pop,
  output logic                            out_debounced_state,
  output logic                            out_lazy_state,
  output logic                            out_press_event,
  output logic                            out_single_event,
  output logic                            out_double_event,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DAT_W-1:0]       cfg_wdata
);

  cfg_t    cfg_r;
  item_t   fq_item, bq_item;
  logic    fq_push, fq_full, bq_empty, bq_pop;
  logic    rq_push, rq_full;
  result_t rq_wdata, rq_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_value  <= ACTIVE_VALUE_RST;
      cfg_r.tolerance     <= TOLERANCE_RST;
      cfg_r.inertia_limit <= INERTIA_LIMIT_RST;
      cfg_r.hold_time_us  <= HOLD_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_VALUE:  cfg_r.active_value  <= cfg_wdata[SAMPLE_W-1:0];
        REG_TOLERANCE:     cfg_r.tolerance     <= cfg_wdata[TOL_W-1:0];
        REG_INERTIA_LIMIT: cfg_r.inertia_limit <= cfg_wdata[INERTIA_W-1:0];
        REG_HOLD_TIME:     cfg_r.hold_time_us  <= cfg_wdata[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bdc_front u_front (
    .in_push   (in_push),
    .in_sample (in_sample),
    .in_now_us (in_now_us),
    .in_full   (in_full),
    .cfg       (cfg_r),
    .q_push    (fq_push),
    .q_item    (fq_item),
    .q_full    (fq_full)
  );

  bdc_queue #(
    .W     ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_item),
    .full  (fq_full),
    .pop   (bq_pop),
    .rdata (bq_item),
    .empty (bq_empty)
  );

  bdc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_item  (bq_item),
    .q_empty (bq_empty),
    .q_pop   (bq_pop),
    .r_push  (rq_push),
    .r_data  (rq_wdata),
    .r_full  (rq_full)
  );

  bdc_queue #(
    .W     ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata (rq_wdata),
    .full  (rq_full),
    .pop   (out_pop),
    .rdata (rq_rdata),
    .empty (out_empty)
  );

  assign out_debounced_state = rq_rdata.debounced_state;
  assign out_lazy_state      = rq_rdata.lazy_state;
  assign out_press_event     = rq_rdata.press_event;
  assign out_single_event    = rq_rdata.single_event;
  assign out_double_event    = rq_rdata.double_event;

endmodule

`default_nettype wire
